// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL. They vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMP(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/pnf_pkg.sv =====
`default_nettype none

package pnf_pkg;

    localparam int STEP_BITS = 3;

    // Extra sum bits above the doubled value; the divisor sum stays below eight times the value.
    localparam int SUM_GUARD = 3;

    typedef logic [STEP_BITS-1:0] step_t;

    localparam step_t S_WAIT     = 3'd0;
    localparam step_t S_SCREEN   = 3'd1;
    localparam step_t S_DIV_INIT = 3'd2;
    localparam step_t S_DIV_STEP = 3'd3;
    localparam step_t S_TEST     = 3'd4;
    localparam step_t S_ADD_D    = 3'd5;
    localparam step_t S_ADD_Q    = 3'd6;
    localparam step_t S_RESULT   = 3'd7;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_ITEM,
        C_TRIVIAL,
        C_DIV_MORE,
        C_Q_LT_D,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        logic  item_rdy;
        logic  div_init;
        logic  div_step;
        logic  add_d;
        logic  add_q;
        logic  emit;
        cond_t cond;
        step_t target;
    } ucw_t;

    typedef struct packed {
        logic item_valid;
        logic trivial;
        logic div_more;
        logic q_lt_d;
        logic out_busy;
    } dp_status_t;

    function automatic ucw_t ucode(input step_t pc);
        ucw_t w;
        w = '0;
        w.cond = C_NEXT;
        w.target = S_WAIT;
        case (pc)
            S_WAIT:
            begin
                w.item_rdy = 1'b1;
                w.cond = C_NO_ITEM;
                w.target = S_WAIT;
            end
            S_SCREEN:
            begin
                w.cond = C_TRIVIAL;
                w.target = S_RESULT;
            end
            S_DIV_INIT:
            begin
                w.div_init = 1'b1;
            end
            S_DIV_STEP:
            begin
                w.div_step = 1'b1;
                w.cond = C_DIV_MORE;
                w.target = S_DIV_STEP;
            end
            S_TEST:
            begin
                w.cond = C_Q_LT_D;
                w.target = S_RESULT;
            end
            S_ADD_D:
            begin
                w.add_d = 1'b1;
            end
            S_ADD_Q:
            begin
                w.add_q = 1'b1;
                w.cond = C_ALWAYS;
                w.target = S_DIV_INIT;
            end
            S_RESULT:
            begin
                // Falls through to step zero once the word has been written out.
                w.emit = 1'b1;
                w.cond = C_OUT_BUSY;
                w.target = S_RESULT;
            end
            default:
            begin
                w.cond = C_ALWAYS;
                w.target = S_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== sv/pnf_item_if.sv =====
`default_nettype none

interface pnf_item_if #(parameter int VALUE_BITS = 16) ();
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;
    logic                         end_of_list;

    modport source (output valid, output value, output end_of_list, input ready);
    modport sink (input valid, input value, input end_of_list, output ready);
endinterface

`default_nettype wire

// ===== sv/pnf_result_if.sv =====
`default_nettype none

interface pnf_result_if #(parameter int VALUE_BITS = 16) ();
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] echo_value;
    logic                         is_perfect;
    logic                         any_found;
    logic                         list_done;

    modport source (output valid, output echo_value, output is_perfect, output any_found,
                    output list_done, input ready);
    modport sink (input valid, input echo_value, input is_perfect, input any_found,
                  input list_done, output ready);
endinterface

`default_nettype wire

// ===== sv/perfect_number_filter.sv =====
`default_nettype none

// Perfect number filter: each word in carries a signed value and an end-of-list mark, and each
// word out gives the value back with a perfect flag, a flag that any value of the list so far
// was perfect, and the end-of-list mark; the list flag clears after the last word of a list.
// Values of one or less are never perfect. One item is worked at a time by an eight-step
// microcoded sequencer driving a shared restoring divider that produces one quotient bit a
// cycle. A value n is divided by each trial divisor from 1 to floor(sqrt(n)) + 1 in turn;
// zero, one and negative values skip the divider. The result sits in an output register, so
// the next word is taken while it waits.
module perfect_number_filter #(
    parameter int VALUE_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    pnf_item_if.sink      item,
    pnf_result_if.source  result
);
    import pnf_pkg::*;

    ucw_t       cw;
    dp_status_t status;

    pnf_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cw     (cw)
    );

    pnf_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cw     (cw),
        .status (status),
        .item   (item),
        .result (result)
    );

endmodule

`default_nettype wire

// ===== sv/pnf_seq.sv =====
`default_nettype none

module pnf_seq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pnf_pkg::dp_status_t   status,
    output pnf_pkg::ucw_t         cw
);
    import pnf_pkg::*;

    step_t pc_reg;
    step_t pc_next;
    logic  taken;

    assign cw = ucode(pc_reg);

    always_comb
    begin
        case (cw.cond)
            C_NEXT:     taken = 1'b0;
            C_ALWAYS:   taken = 1'b1;
            C_NO_ITEM:  taken = !status.item_valid;
            C_TRIVIAL:  taken = status.trivial;
            C_DIV_MORE: taken = status.div_more;
            C_Q_LT_D:   taken = status.q_lt_d;
            C_OUT_BUSY: taken = status.out_busy;
            default:    taken = 1'b0;
        endcase
        pc_next = taken ? cw.target : pc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= S_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/pnf_dp.sv =====
`default_nettype none
`include "assert_macros.svh"

module pnf_dp #(
    parameter int VALUE_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pnf_pkg::ucw_t       cw,
    output pnf_pkg::dp_status_t status,
    pnf_item_if.sink            item,
    pnf_result_if.source        result
);
    import pnf_pkg::*;

    localparam int NB = VALUE_BITS - 1;
    localparam int SB = VALUE_BITS + SUM_GUARD;
    localparam int CB = (NB > 1) ? $clog2(NB) : 1;
    localparam logic [CB-1:0] CNT_LAST = CB'(NB - 1);

    logic signed [VALUE_BITS-1:0] echo_reg;
    logic                         last_reg;
    logic                         trivial_reg;
    logic [NB-1:0]                n_reg;
    logic [NB-1:0]                d_reg;
    logic [NB-1:0]                q_reg;
    logic [NB-1:0]                rem_reg;
    logic [CB-1:0]                cnt_reg;
    logic [SB-1:0]                sum_reg;

    logic signed [VALUE_BITS-1:0] out_echo_reg;
    logic                         out_perf_reg;
    logic                         out_any_reg;
    logic                         out_last_reg;
    logic                         out_valid_reg;
    logic                         seen_reg;

    logic          take;
    logic          out_free;
    logic          emit_now;
    logic [NB:0]   shifted;
    logic [NB:0]   diff;
    logic          ge;
    logic          rem_zero;
    logic          perf;
    logic          any;

    assign take     = item.valid && cw.item_rdy;
    assign out_free = !out_valid_reg || result.ready;
    assign emit_now = cw.emit && out_free;

    // One restoring division bit per cycle: quotient bits shift into q_reg.
    assign shifted  = {rem_reg, q_reg[NB-1]};
    assign ge       = shifted >= {1'b0, d_reg};
    assign diff     = shifted - {1'b0, d_reg};
    assign rem_zero = rem_reg == '0;

    // The sum holds every divisor including the value itself, so a perfect value gives twice it.
    assign perf = !trivial_reg && (sum_reg == {{SUM_GUARD{1'b0}}, n_reg, 1'b0});
    assign any  = seen_reg || perf;

    assign item.ready = cw.item_rdy;

    assign result.valid      = out_valid_reg;
    assign result.echo_value = out_echo_reg;
    assign result.is_perfect = out_perf_reg;
    assign result.any_found  = out_any_reg;
    assign result.list_done  = out_last_reg;

    assign status.item_valid = item.valid;
    assign status.trivial    = trivial_reg;
    assign status.div_more   = cnt_reg != CNT_LAST;
    assign status.q_lt_d     = q_reg < d_reg;
    assign status.out_busy   = !out_free;

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            echo_reg    <= item.value;
            last_reg    <= item.end_of_list;
            n_reg       <= item.value[NB-1:0];
            trivial_reg <= item.value[VALUE_BITS-1] || (item.value[NB-1:0] <= NB'(1));
            d_reg       <= NB'(1);
            sum_reg     <= '0;
        end
        if (cw.div_init)
        begin
            q_reg   <= n_reg;
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        if (cw.div_step)
        begin
            q_reg   <= {q_reg[NB-2:0], ge};
            rem_reg <= ge ? diff[NB-1:0] : shifted[NB-1:0];
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cw.add_d && rem_zero)
        begin
            sum_reg <= sum_reg + SB'(d_reg);
        end
        if (cw.add_q)
        begin
            if (rem_zero && (q_reg != d_reg))
            begin
                sum_reg <= sum_reg + SB'(q_reg);
            end
            d_reg <= d_reg + 1'b1;
        end
        if (emit_now)
        begin
            out_echo_reg <= echo_reg;
            out_perf_reg <= perf;
            out_any_reg  <= any;
            out_last_reg <= last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            seen_reg      <= 1'b0;
        end
        else
        begin
            if (emit_now)
            begin
                out_valid_reg <= 1'b1;
                seen_reg      <= last_reg ? 1'b0 : any;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    `ASSERT_IMP(a_rem_below_div, clk, rst_n, cw.div_step, (d_reg != '0) && (rem_reg < d_reg))
    `ASSERT_IMP(a_add_after_test, clk, rst_n, cw.add_d, !(q_reg < d_reg))
    `ASSERT_NEXT(a_emit_shows, clk, rst_n, emit_now, result.valid && (result.is_perfect == $past(perf)))
    `ASSERT_NEXT(a_list_clears, clk, rst_n, emit_now && last_reg, !seen_reg)

endmodule

`default_nettype wire
